FILE: hw/rtl/fsts_pkg.sv
package fsts_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned TID_W    = 4;
  localparam int unsigned PRIO_W   = 6;
  localparam int unsigned CLS_W    = 2;
  localparam int unsigned QUANT_W  = 8;
  localparam int unsigned BIAS_W   = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned WEIGHT_W = 31;
  localparam int unsigned DIVD_W   = 42;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 112;

  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WAKE     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_YIELD    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BLOCK    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PRE_OFF  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PRE_ON   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SET_PRIO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SET_CLS  = 3'd7;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [CLS_W-1:0] CLS_IO  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_NET = 2'd2;
  localparam logic [CLS_W-1:0] CLS_CPU = 2'd3;

  localparam logic [1:0] RS_BLOCKED = 2'd0;
  localparam logic [1:0] RS_READY   = 2'd1;
  localparam logic [1:0] RS_RUNNING = 2'd2;

  localparam logic [0:0] CFG_QUANTUM = 1'd0;
  localparam logic [0:0] CFG_BIAS    = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic decode;    // apply simple request, decide next step
    logic requeue;   // start weight and divide of outgoing task
    logic enq;       // write quotient, queue outgoing task
    logic scan_clr;  // reset scan pointer and best
    logic scan_step; // examine one slot
    logic pick;      // dequeue best and switch
    logic emit;      // load output register
  } fsts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sched;
    logic need_requeue;
    logic div_done;
    logic scan_last;
  } fsts_sts_t;

  // 1024 scaled by nice, class bias and floor
  function automatic logic [WEIGHT_W-1:0] task_weight(input logic signed [PRIO_W-1:0] nice,
                                                     input logic [CLS_W-1:0] cls,
                                                     input logic [BIAS_W-1:0] bias);
    logic [WEIGHT_W-1:0] w;
    logic signed [PRIO_W-1:0] n;
    n = nice;
    if (n < -6'sd20) n = -6'sd20;
    if (n > 6'sd19) n = 6'sd19;
    w = WEIGHT_W'(1024);
    if (n < 0) w = w << 5'(-n);
    else w = w >> 5'(n);
    if (cls == CLS_IO || cls == CLS_NET) w = w + (w >> 2) + WEIGHT_W'(bias >> 6);
    else if (cls == CLS_CPU && w > WEIGHT_W'(256)) w = w - (w >> 3);
    if (w < WEIGHT_W'(64)) w = WEIGHT_W'(64);
    return w;
  endfunction

endpackage

FILE: hw/rtl/fair_share_task_scheduler.sv
// an event that does not reschedule goes from decode to emit; a reschedule adds the
// slot scan and pick, and the weighted vruntime divide runs first when the outgoing task requeues
// throughput: one event at a time; the radix-2 divider, the one-slot-per-cycle scan
// and a stalled output all hold off the next event
// reset: synchronous, slot 0 running, quantum 3, all counters and queues cleared
module fair_share_task_scheduler #(
  parameter int unsigned NUM_TASKS     = 16,
  parameter int unsigned IDLE_SLOT     = 1,
  parameter int unsigned VRUNTIME_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[2:0], task_id[6:3], new_priority[12:7], new_class[14:13], zero pad
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // running_task[3:0], switched[4], slice_remaining[12:5], status[14:13],
  // total_ticks[46:15], idle_ticks[78:47], switch_count[110:79], zero pad
  output logic [111:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import fsts_pkg::*;

  fsts_cmd_t cmd;
  fsts_sts_t sts;
  logic      out_valid_r;
  logic      in_fire;

  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  fsts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (out_valid_r && !out_tready),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  fsts_datapath #(
    .NUM_TASKS     (NUM_TASKS),
    .IDLE_SLOT     (IDLE_SLOT),
    .VRUNTIME_BITS (VRUNTIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_tdata),
    .cfg_fire  (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_tdata)
  );

endmodule

FILE: hw/rtl/fsts_ctrl.sv
module fsts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_busy,
  output logic             in_ready,
  output fsts_pkg::fsts_cmd_t cmd,
  input  fsts_pkg::fsts_sts_t sts
);
  import fsts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_ENQ  = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_PICK = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_DEC;
      S_DEC: begin
        cmd.decode = 1'b1;
        if (!sts.need_sched) state_nxt = S_EMIT;
        else if (sts.need_requeue) begin
          cmd.requeue = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DIV: if (sts.div_done) state_nxt = S_ENQ;
      S_ENQ: begin
        cmd.enq = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

FILE: hw/rtl/fsts_datapath.sv
module fsts_datapath #(
  parameter int unsigned NUM_TASKS     = 16,
  parameter int unsigned IDLE_SLOT     = 1,
  parameter int unsigned VRUNTIME_BITS = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [fsts_pkg::IN_W-1:0]   in_item,
  input  logic                        cfg_fire,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  fsts_pkg::fsts_cmd_t         cmd,
  output fsts_pkg::fsts_sts_t         sts,
  output logic [fsts_pkg::OUT_W-1:0]  out_item
);
  import fsts_pkg::*;

  localparam int unsigned SW   = $clog2(NUM_TASKS);
  localparam int unsigned RW   = $clog2(NUM_TASKS + 1);
  localparam int unsigned QW   = (VRUNTIME_BITS > DIVD_W) ? VRUNTIME_BITS : DIVD_W;
  localparam int unsigned DCW  = $clog2(DIVD_W + 1);
  localparam logic [SW-1:0] IDLE = SW'(IDLE_SLOT);

  logic [QUANT_W-1:0] quantum_r;
  logic [BIAS_W-1:0]  bias_r;

  logic signed [PRIO_W-1:0]   prio_r  [NUM_TASKS];
  logic [CLS_W-1:0]           cls_r   [NUM_TASKS];
  logic [CNT_W-1:0]           rt_r    [NUM_TASKS];
  logic [VRUNTIME_BITS-1:0]   vr_r    [NUM_TASKS];
  logic [NUM_TASKS-1:0]       q_r;
  logic [1:0]                 rs_r    [NUM_TASKS];
  logic [RW-1:0]              rank_r  [NUM_TASKS];

  logic [SW-1:0]             cur_r;
  logic [QUANT_W-1:0]        slice_r;
  logic [VRUNTIME_BITS-1:0]  base_r;
  logic [7:0]                pdepth_r;
  logic [CNT_W-1:0]          ttot_r, tidle_r, swtot_r;

  logic [REQ_W-1:0]          req_r;
  logic [TID_W-1:0]          tid_r;
  logic signed [PRIO_W-1:0]  nprio_r;
  logic [CLS_W-1:0]          ncls_r;
  logic                      sched_r, sw_r;
  logic [STAT_W-1:0]         stat_r;

  // divider
  logic [DIVD_W-1:0]   dnum_r;
  logic [QW-1:0]       quo_r;
  logic [WEIGHT_W:0]   rem_r;
  logic [WEIGHT_W-1:0] wgt_r;
  logic [DCW-1:0]      dcnt_r;
  logic                dbusy_r;

  // scanner
  logic [SW:0]              sidx_r;
  logic                     bfound_r;
  logic [SW-1:0]            best_r;
  logic [VRUNTIME_BITS-1:0] bvr_r;
  logic [RW-1:0]            brank_r;

  logic [OUT_W-1:0] out_r;

  logic          tid_ok;
  logic [SW-1:0] tid_s;
  logic          dec_sched, dec_requeue;
  logic [RW-1:0] qcount;
  logic [WEIGHT_W:0] rem_sh;
  logic [SW-1:0] sslot;
  logic          better;
  logic [CNT_W-1:0] rt_inc;
  logic [SW-1:0] next_slot;

  assign tid_ok = (32'(tid_r) < NUM_TASKS);
  assign tid_s  = SW'(tid_r);
  assign rt_inc = rt_r[cur_r] + 1'b1;

  always_comb begin
    qcount = '0;
    for (int i = 0; i < NUM_TASKS; i++) qcount = qcount + RW'(q_r[i]);
  end

  // would this request reschedule, and is the outgoing task requeued
  always_comb begin
    logic [QUANT_W-1:0] s;
    s = (slice_r != 0) ? slice_r - 1'b1 : slice_r;
    dec_sched = 1'b0;
    unique case (req_r)
      REQ_TICK:  dec_sched = (pdepth_r == 0) && (s == 0);
      REQ_YIELD: dec_sched = 1'b1;
      REQ_BLOCK: dec_sched = (cur_r != IDLE);
      default:   dec_sched = 1'b0;
    endcase
    dec_requeue = (req_r != REQ_BLOCK) && (rs_r[cur_r] == RS_RUNNING) && (cur_r != IDLE);
  end

  assign sts.need_sched   = dec_sched;
  assign sts.need_requeue = dec_requeue;
  assign sts.div_done     = !dbusy_r;
  assign sts.scan_last    = (sidx_r == (SW+1)'(NUM_TASKS - 1));

  assign rem_sh = {rem_r[WEIGHT_W-1:0], dnum_r[DIVD_W-1]};
  assign sslot  = sidx_r[SW-1:0];
  assign better = q_r[sslot] && (!bfound_r || vr_r[sslot] < bvr_r ||
                  (vr_r[sslot] == bvr_r && rank_r[sslot] < brank_r));
  assign next_slot = bfound_r ? best_r : IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANT_W'(3);
      bias_r    <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        prio_r[i] <= '0;
        cls_r[i]  <= '0;
        rt_r[i]   <= '0;
        vr_r[i]   <= '0;
        rs_r[i]   <= (i == 0) ? RS_RUNNING : RS_BLOCKED;
        rank_r[i] <= '0;
      end
      q_r      <= '0;
      cur_r    <= '0;
      slice_r  <= QUANT_W'(3);
      base_r   <= '0;
      pdepth_r <= '0;
      ttot_r   <= '0;
      tidle_r  <= '0;
      swtot_r  <= '0;
      dbusy_r  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        if (cfg_index == CFG_QUANTUM) quantum_r <= cfg_data[QUANT_W-1:0];
        else bias_r <= cfg_data[BIAS_W-1:0];
      end
      if (cmd.decode) begin
        unique case (req_r)
          REQ_TICK: begin
            ttot_r <= ttot_r + 1'b1;
            if (cur_r == IDLE || cur_r == '0) tidle_r <= tidle_r + 1'b1;
            if (pdepth_r == 0 && slice_r != 0) slice_r <= slice_r - 1'b1;
          end
          REQ_WAKE: begin
            if (tid_ok && tid_s != IDLE && tid_s != cur_r && !q_r[tid_s]) begin
              rs_r[tid_s]   <= RS_READY;
              vr_r[tid_s]   <= base_r;
              rank_r[tid_s] <= qcount;
              q_r[tid_s]    <= 1'b1;
            end
          end
          REQ_BLOCK: if (cur_r != IDLE) rs_r[cur_r] <= RS_BLOCKED;
          REQ_PRE_OFF: if (pdepth_r != 8'hff) pdepth_r <= pdepth_r + 1'b1;
          REQ_PRE_ON:  if (pdepth_r != 0) pdepth_r <= pdepth_r - 1'b1;
          REQ_SET_PRIO:
            if (nprio_r >= -6'sd20 && nprio_r <= 6'sd19 && tid_ok) prio_r[tid_s] <= nprio_r;
          REQ_SET_CLS: if (tid_ok) cls_r[tid_s] <= ncls_r;
          default: ;
        endcase
      end
      if (cmd.requeue) begin
        rt_r[cur_r] <= rt_inc;
        dbusy_r     <= 1'b1;
      end else if (dbusy_r && dcnt_r == DCW'(1)) begin
        dbusy_r <= 1'b0;
      end
      if (cmd.enq) begin
        vr_r[cur_r]   <= quo_r[VRUNTIME_BITS-1:0];
        rank_r[cur_r] <= qcount;
        q_r[cur_r]    <= 1'b1;
        rs_r[cur_r]   <= RS_READY;
      end
      if (cmd.pick) begin
        if (bfound_r) begin
          for (int i = 0; i < NUM_TASKS; i++)
            if (q_r[i] && rank_r[i] > brank_r) rank_r[i] <= rank_r[i] - 1'b1;
          q_r[best_r]    <= 1'b0;
          rank_r[best_r] <= '0;
          base_r         <= bvr_r;
        end
        rs_r[next_slot] <= RS_RUNNING;
        slice_r <= quantum_r;
        if (next_slot != cur_r) begin
          if (cur_r == IDLE) rs_r[cur_r] <= RS_BLOCKED;
          swtot_r <= swtot_r + 1'b1;
          cur_r   <= next_slot;
        end
      end
    end
  end

  // payload and shared working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_item[2:0];
      tid_r   <= in_item[6:3];
      nprio_r <= in_item[12:7];
      ncls_r  <= in_item[14:13];
      sw_r    <= 1'b0;
    end
    if (cmd.decode) begin
      sched_r <= dec_sched;
      stat_r  <= ST_DONE;
      unique case (req_r)
        REQ_WAKE:
          if (!tid_ok || tid_s == IDLE || tid_s == cur_r || q_r[tid_s]) stat_r <= ST_IGNORED;
        REQ_BLOCK: if (cur_r == IDLE) stat_r <= ST_IGNORED;
        REQ_PRE_ON: if (pdepth_r == 0) stat_r <= ST_IGNORED;
        REQ_SET_PRIO:
          if (nprio_r < -6'sd20 || nprio_r > 6'sd19) stat_r <= ST_RANGE;
          else if (!tid_ok) stat_r <= ST_IGNORED;
        REQ_SET_CLS: if (!tid_ok) stat_r <= ST_IGNORED;
        default: ;
      endcase
    end
    // restoring divide of runtime*1024 by weight, one quotient bit per cycle
    if (cmd.requeue) begin
      dnum_r <= {rt_inc, 10'd0};
      wgt_r  <= task_weight(prio_r[cur_r], cls_r[cur_r], bias_r);
      rem_r  <= '0;
      quo_r  <= '0;
      dcnt_r <= DCW'(DIVD_W);
    end else if (dbusy_r) begin
      dnum_r <= dnum_r << 1;
      dcnt_r <= dcnt_r - 1'b1;
      if (rem_sh >= {1'b0, wgt_r}) begin
        rem_r <= rem_sh - {1'b0, wgt_r};
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.scan_clr) begin
      sidx_r   <= '0;
      bfound_r <= 1'b0;
    end else if (cmd.scan_step) begin
      sidx_r <= sidx_r + 1'b1;
      if (better) begin
        bfound_r <= 1'b1;
        best_r   <= sslot;
        bvr_r    <= vr_r[sslot];
        brank_r  <= rank_r[sslot];
      end
    end
    if (cmd.pick) sw_r <= (next_slot != cur_r);
    if (cmd.emit) begin
      out_r <= {1'b0, swtot_r, tidle_r, ttot_r, stat_r, slice_r,
                (sched_r && sw_r), TID_W'(cur_r)};
    end
  end

  assign out_item = out_r;

endmodule
